@@ hw/rtl/aes128_pkg.sv @@
package aes128_pkg;

    localparam int unsigned HALF_W     = 64;
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W  = 8;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [7:0]         t_byte;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    localparam logic [8:0] GF_POLY   = 9'h11B;
    localparam t_byte      AFFINE_C  = 8'h63;

    localparam t_byte RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        logic [8:0] x;
        t_byte      acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    // Inverse as x^254, which maps zero to zero.
    function automatic t_byte gf_inv(input t_byte x);
        t_byte       res;
        t_byte       base;
        logic [7:0]  e;
        res  = 8'h01;
        base = x;
        e    = 8'd254;
        for (int j = 0; j < 8; j++) begin
            if (e[j]) begin
                res = gf_mul(res, base);
            end
            base = gf_mul(base, base);
        end
        return res;
    endfunction

    function automatic logic [2047:0] build_sbox();
        logic [2047:0] tbl;
        t_byte         b;
        t_byte         s;
        tbl = '0;
        for (int i = 0; i < 256; i++) begin
            b = gf_inv(t_byte'(i));
            s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                ^ {b[3:0], b[7:4]} ^ AFFINE_C;
            tbl[i*8 +: 8] = s;
        end
        return tbl;
    endfunction

    localparam logic [2047:0] SBOX_TABLE = build_sbox();

    function automatic t_byte sub_byte(input t_byte x);
        return SBOX_TABLE[{x, 3'b000} +: 8];
    endfunction

    // Byte i of a block sits at bits 127-8i down to 120-8i.
    function automatic t_byte get_byte(input t_block s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_block sub_shift(input t_block st);
        t_block res;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                res[BLOCK_W-1-8*(4*c+r) -: 8] = sub_byte(get_byte(st, 4*((c+r)%4)+r));
            end
        end
        return res;
    endfunction

    function automatic t_block mix_columns(input t_block st);
        t_block res;
        t_byte  a0, a1, a2, a3;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(st, 4*c);
            a1 = get_byte(st, 4*c+1);
            a2 = get_byte(st, 4*c+2);
            a3 = get_byte(st, 4*c+3);
            res[BLOCK_W-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            res[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            res[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            res[BLOCK_W-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return res;
    endfunction

    function automatic t_block next_key(input t_block k, input t_byte rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {sub_byte(get_byte(k, 13)) ^ rc, sub_byte(get_byte(k, 14)),
              sub_byte(get_byte(k, 15)), sub_byte(get_byte(k, 12))};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

@@ hw/rtl/aes128_round.sv @@
module aes128_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aes128_pkg::t_block   i_state,
    input  aes128_pkg::t_block   i_key,
    input  aes128_pkg::t_byte    i_rcon,
    input  logic                 i_final,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aes128_pkg::t_block   o_state,
    output aes128_pkg::t_block   o_key
);

    logic               r_valid;
    aes128_pkg::t_block r_state;
    aes128_pkg::t_block r_key;
    aes128_pkg::t_block n_state;
    aes128_pkg::t_block n_key;
    aes128_pkg::t_block w_sub;

    always_comb begin
        n_key   = aes128_pkg::next_key(i_key, i_rcon);
        w_sub   = aes128_pkg::sub_shift(i_state);
        n_state = (i_final ? w_sub : aes128_pkg::mix_columns(w_sub)) ^ n_key;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

@@ hw/rtl/aes128_block_encrypt_top.sv @@
// AES-128 encryption pipeline: one input register with the initial key addition, then ten round stages.
// An accepted request passes the input register and then each of the ten round registers before it reaches the output.
// Throughput is one block per cycle; a stall on the output backs up stage by stage without loss.
// Synchronous active-low reset empties all stages and clears both key registers to zero.
module aes128_block_encrypt_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [63:0] plain_high, [127:64] plain_low
    input  logic [aes128_pkg::BLOCK_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [63:0] cipher_high, [127:64] cipher_low
    output logic [aes128_pkg::BLOCK_W-1:0]      o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aes128_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aes128_pkg::HALF_W-1:0]       i_cfg_data
);

    localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

    logic [aes128_pkg::HALF_W-1:0] r_key_high;
    logic [aes128_pkg::HALF_W-1:0] r_key_low;

    logic               w_valid [NR+1];
    logic               w_ready [NR+1];
    aes128_pkg::t_block w_state [NR+1];
    aes128_pkg::t_block w_key   [NR+1];

    logic               r_valid0;
    aes128_pkg::t_block r_state0;
    aes128_pkg::t_block r_key0;
    aes128_pkg::t_block w_cfg_key;
    aes128_pkg::t_block w_plain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aes128_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes128_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg_key       = {r_key_high, r_key_low};
    assign w_plain         = {i_s_axis_tdata[aes128_pkg::HALF_W-1:0],
                              i_s_axis_tdata[aes128_pkg::BLOCK_W-1:aes128_pkg::HALF_W]};
    assign o_s_axis_tready = !r_valid0 || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid0 <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_state0 <= w_plain ^ w_cfg_key;
            r_key0   <= w_cfg_key;
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_state[0] = r_state0;
    assign w_key[0]   = r_key0;

    for (genvar g = 0; g < NR; g++) begin : g_round
        aes128_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .i_rcon  (aes128_pkg::RCON[g]),
            .i_final ((g == NR - 1) ? 1'b1 : 1'b0),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    assign w_ready[NR]     = i_m_axis_tready;
    assign o_m_axis_tvalid = w_valid[NR];
    assign o_m_axis_tdata  = {w_state[NR][aes128_pkg::HALF_W-1:0],
                              w_state[NR][aes128_pkg::BLOCK_W-1:aes128_pkg::HALF_W]};

endmodule
